### rtl/fspq_pkg.sv
// Shared types and constants of the frontier shortest-path query engine.
`timescale 1ns / 1ps
package fspq_pkg;

  localparam int unsigned DIST_BITS = 22;
  localparam logic [DIST_BITS-1:0] DIST_SAT = '1;
  localparam logic [5:0] PATH_MAX = 6'd62;

  localparam logic REQ_ADD = 1'b0;

  localparam logic [1:0] KIND_DIST    = 2'd0;
  localparam logic [1:0] KIND_PATH    = 2'd1;
  localparam logic [1:0] KIND_STORED  = 2'd2;
  localparam logic [1:0] KIND_DROPPED = 2'd3;

  typedef struct packed {
    logic        req_type;
    logic [5:0]  src_node;
    logic [5:0]  dst_node;
    logic [15:0] edge_weight;
    logic        want_path;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [21:0] value;
    logic        unreachable;
    logic        last;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_ADD_LINK, S_ROUND, S_NODE_RD, S_NODE_U, S_NODE_E,
    S_EDGE_CHK, S_EDGE_DV, S_EDGE_UPD, S_FIN_RD, S_FIN, S_WALK, S_DIST_OUT,
    S_PATH_RD, S_PATH_OUT
  } state_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_LATCH, CMD_DROP, CMD_ADD_WRITE, CMD_ADD_LINK, CMD_Q_UNREACH,
    CMD_Q_ZERO, CMD_Q_INIT, CMD_ROUND_START, CMD_ROUND_END, CMD_NODE_RD,
    CMD_NODE_U, CMD_NODE_E, CMD_EDGE_RD, CMD_EDGE_DV, CMD_EDGE_UPD, CMD_FIN_RD,
    CMD_WALK_INIT, CMD_WALK_STEP, CMD_DIST_OUT, CMD_PATH_RD, CMD_PATH_OUT
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic bad_node;
    logic full;
    logic same_node;
    logic out_free;
    logic frontier_empty;
    logic round_done;
    logic edge_end;
    logic walk_go;
    logic dest_reached;
    logic want_path;
    logic path_empty;
    logic path_last;
  } status_t;

endpackage

### rtl/fspq_req_if.sv
// Request channel interface carrying one input transaction.
`timescale 1ns / 1ps
interface fspq_req_if import fspq_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/fspq_res_if.sv
// Result channel interface carrying one output transaction.
`timescale 1ns / 1ps
interface fspq_res_if import fspq_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/fspq_ctrl.sv
// Controller state machine sequencing edge insertion, relaxation and path output.
`timescale 1ns / 1ps
module fspq_ctrl import fspq_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op = CMD_NONE;
    req_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.op = CMD_LATCH;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!status.is_query) begin
          if (status.bad_node || status.full) begin
            if (status.out_free) begin
              cmd.op = CMD_DROP;
              state_next = S_IDLE;
            end
          end else begin
            cmd.op = CMD_ADD_WRITE;
            state_next = S_ADD_LINK;
          end
        end else if (status.bad_node) begin
          if (status.out_free) begin
            cmd.op = CMD_Q_UNREACH;
            state_next = S_IDLE;
          end
        end else if (status.same_node) begin
          if (status.out_free) begin
            cmd.op = CMD_Q_ZERO;
            state_next = S_IDLE;
          end
        end else begin
          cmd.op = CMD_Q_INIT;
          state_next = S_ROUND;
        end
      end
      S_ADD_LINK: begin
        if (status.out_free) begin
          cmd.op = CMD_ADD_LINK;
          state_next = S_IDLE;
        end
      end
      S_ROUND: begin
        if (status.frontier_empty) begin
          state_next = S_FIN_RD;
        end else begin
          cmd.op = CMD_ROUND_START;
          state_next = S_NODE_RD;
        end
      end
      S_NODE_RD: begin
        if (status.round_done) begin
          cmd.op = CMD_ROUND_END;
          state_next = S_ROUND;
        end else begin
          cmd.op = CMD_NODE_RD;
          state_next = S_NODE_U;
        end
      end
      S_NODE_U: begin
        cmd.op = CMD_NODE_U;
        state_next = S_NODE_E;
      end
      S_NODE_E: begin
        cmd.op = CMD_NODE_E;
        state_next = S_EDGE_CHK;
      end
      S_EDGE_CHK: begin
        if (status.edge_end) begin
          state_next = S_NODE_RD;
        end else begin
          cmd.op = CMD_EDGE_RD;
          state_next = S_EDGE_DV;
        end
      end
      S_EDGE_DV: begin
        cmd.op = CMD_EDGE_DV;
        state_next = S_EDGE_UPD;
      end
      S_EDGE_UPD: begin
        cmd.op = CMD_EDGE_UPD;
        state_next = S_EDGE_CHK;
      end
      S_FIN_RD: begin
        cmd.op = CMD_FIN_RD;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!status.dest_reached) begin
          if (status.out_free) begin
            cmd.op = CMD_Q_UNREACH;
            state_next = S_IDLE;
          end
        end else if (status.want_path) begin
          cmd.op = CMD_WALK_INIT;
          state_next = S_WALK;
        end else begin
          state_next = S_DIST_OUT;
        end
      end
      S_WALK: begin
        if (status.walk_go) begin
          cmd.op = CMD_WALK_STEP;
        end else begin
          state_next = S_DIST_OUT;
        end
      end
      S_DIST_OUT: begin
        if (status.out_free) begin
          cmd.op = CMD_DIST_OUT;
          state_next = status.path_empty ? S_IDLE : S_PATH_RD;
        end
      end
      S_PATH_RD: begin
        cmd.op = CMD_PATH_RD;
        state_next = S_PATH_OUT;
      end
      S_PATH_OUT: begin
        if (status.out_free) begin
          cmd.op = CMD_PATH_OUT;
          state_next = status.path_last ? S_IDLE : S_PATH_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/fspq_dp.sv
// Datapath holding the edge table, distance store, frontiers and result register.
`timescale 1ns / 1ps
module fspq_dp import fspq_pkg::*; #(
  parameter int unsigned NODES       = 64,
  parameter int unsigned EDGES       = 1024,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  cmd_t    cmd,
  input  req_t    req_data,
  output status_t status,
  output logic    res_valid,
  input  logic    res_ready,
  output res_t    res_data
);

  localparam int unsigned NB = $clog2(NODES);
  localparam int unsigned CW = $clog2(NODES + 1);
  localparam int unsigned EA = $clog2(EDGES);
  localparam int unsigned EB = $clog2(EDGES + 1);
  localparam int unsigned SW = ((WEIGHT_BITS > DIST_BITS) ? WEIGHT_BITS : DIST_BITS) + 1;

  req_t it;
  logic [NB-1:0] s_idx, d_idx;

  logic [EB-1:0] edge_count;
  logic [EA-1:0] new_e;
  logic          had_first;

  logic [NB-1:0]          edge_dest [EDGES];
  logic [WEIGHT_BITS-1:0] edge_len  [EDGES];
  logic [EB-1:0]          edge_link [EDGES];
  logic [EB-1:0]          node_first [NODES];
  logic [EA-1:0]          node_final [NODES];
  logic [DIST_BITS-1:0]   dist_mem [NODES];
  logic [NB-1:0]          pred [NODES];
  logic [NB-1:0]          fr_a [NODES];
  logic [NB-1:0]          fr_b [NODES];
  logic [NB-1:0]          stack [64];

  logic [NODES-1:0] first_valid;
  logic [NODES-1:0] dvalid;
  logic [NODES-1:0] queued;

  logic [NB-1:0]          ed_rd;
  logic [WEIGHT_BITS-1:0] el_rd;
  logic [EB-1:0]          lk_rd;
  logic [EB-1:0]          nfirst_rd;
  logic [EA-1:0]          nf_rd;
  logic [DIST_BITS-1:0]   dist_rd;
  logic                   dist_vrd;
  logic [NB-1:0]          pred_rd;
  logic [NB-1:0]          fr_a_rd, fr_b_rd, fr_rd;
  logic [NB-1:0]          st_rd;

  logic                 fsel;
  logic [CW-1:0]        now_n, next_n, i;
  logic [NB-1:0]        u;
  logic                 fv;
  logic [EB-1:0]        e;
  logic [DIST_BITS-1:0] du;
  logic [CW-1:0]        steps;
  logic [5:0]           wp, rp, kcnt, rem;

  logic                 dist_re;
  logic [NB-1:0]        dist_ra;
  logic [SW-1:0]        cand_sum;
  logic [DIST_BITS-1:0] cand;
  logic                 improve, push;
  logic                 load_out;
  res_t                 res_next;
  logic                 out_valid;

  assign s_idx = NB'(it.src_node);
  assign d_idx = NB'(it.dst_node);
  assign fr_rd = fsel ? fr_b_rd : fr_a_rd;

  assign cand_sum = SW'(du) + SW'(el_rd);
  assign cand     = (cand_sum > SW'(DIST_SAT)) ? DIST_SAT : cand_sum[DIST_BITS-1:0];
  assign improve  = (cmd.op == CMD_EDGE_UPD) && (32'(ed_rd) < NODES) &&
                    (!dist_vrd || (cand < dist_rd));
  assign push     = improve && !queued[ed_rd] && (32'(next_n) < NODES);

  always_comb begin
    dist_re = 1'b1;
    dist_ra = d_idx;
    case (cmd.op)
      CMD_NODE_U:  dist_ra = fr_rd;
      CMD_EDGE_DV: dist_ra = ed_rd;
      CMD_FIN_RD:  dist_ra = d_idx;
      default:     dist_re = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == CMD_LATCH) begin
      it <= req_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == CMD_ADD_WRITE) begin
      edge_dest[edge_count[EA-1:0]] <= d_idx;
      edge_len[edge_count[EA-1:0]]  <= WEIGHT_BITS'(it.edge_weight);
    end
    if (cmd.op == CMD_EDGE_RD) begin
      ed_rd <= edge_dest[e[EA-1:0]];
      el_rd <= edge_len[e[EA-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == CMD_ADD_WRITE) begin
      edge_link[edge_count[EA-1:0]] <= EB'(EDGES);
    end else if (cmd.op == CMD_ADD_LINK && had_first) begin
      edge_link[nf_rd] <= EB'(new_e);
    end
    if (cmd.op == CMD_EDGE_RD) begin
      lk_rd <= edge_link[e[EA-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == CMD_ADD_WRITE) begin
      node_final[s_idx] <= edge_count[EA-1:0];
      nf_rd <= node_final[s_idx];
      had_first <= first_valid[s_idx];
      new_e <= edge_count[EA-1:0];
      if (!first_valid[s_idx]) begin
        node_first[s_idx] <= EB'(edge_count[EA-1:0]);
      end
    end
    if (cmd.op == CMD_NODE_U) begin
      nfirst_rd <= node_first[fr_rd];
      fv <= first_valid[fr_rd];
      u <= fr_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count <= '0;
      first_valid <= '0;
    end else if (cmd.op == CMD_ADD_WRITE) begin
      edge_count <= edge_count + 1'b1;
      first_valid[s_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == CMD_Q_INIT) begin
      dist_mem[s_idx] <= '0;
    end else if (improve) begin
      dist_mem[ed_rd] <= cand;
    end
    if (dist_re) begin
      dist_rd <= dist_mem[dist_ra];
      dist_vrd <= dvalid[dist_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dvalid <= '0;
      queued <= '0;
    end else begin
      if (cmd.op == CMD_Q_INIT) begin
        dvalid <= NODES'(1) << s_idx;
        queued <= '0;
      end else if (cmd.op == CMD_ROUND_END) begin
        queued <= '0;
      end
      if (improve) begin
        dvalid[ed_rd] <= 1'b1;
      end
      if (push) begin
        queued[ed_rd] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (improve) begin
      pred[ed_rd] <= u;
    end
    if (cmd.op == CMD_WALK_INIT) begin
      pred_rd <= pred[d_idx];
    end else if (cmd.op == CMD_WALK_STEP) begin
      pred_rd <= pred[pred_rd];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == CMD_Q_INIT) begin
      fr_a[0] <= s_idx;
    end else if (push && fsel) begin
      fr_a[next_n[NB-1:0]] <= ed_rd;
    end
    if (push && !fsel) begin
      fr_b[next_n[NB-1:0]] <= ed_rd;
    end
    if (cmd.op == CMD_NODE_RD) begin
      fr_a_rd <= fr_a[i[NB-1:0]];
      fr_b_rd <= fr_b[i[NB-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == CMD_WALK_STEP) begin
      stack[wp] <= pred_rd;
    end
    if (cmd.op == CMD_PATH_RD) begin
      st_rd <= stack[rp];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsel <= 1'b0;
      now_n <= '0;
      next_n <= '0;
      i <= '0;
      e <= '0;
      du <= '0;
      steps <= '0;
      wp <= '0;
      rp <= '0;
      kcnt <= '0;
      rem <= '0;
    end else begin
      unique case (cmd.op)
        CMD_Q_INIT: begin
          fsel <= 1'b0;
          now_n <= CW'(1);
          kcnt <= '0;
        end
        CMD_ROUND_START: begin
          i <= '0;
          next_n <= '0;
        end
        CMD_ROUND_END: begin
          fsel <= ~fsel;
          now_n <= next_n;
        end
        CMD_NODE_RD: i <= i + 1'b1;
        CMD_NODE_E: begin
          e <= fv ? nfirst_rd : EB'(EDGES);
          du <= dist_rd;
        end
        CMD_EDGE_UPD: begin
          e <= lk_rd;
          if (push) begin
            next_n <= next_n + 1'b1;
          end
        end
        CMD_WALK_INIT: begin
          steps <= '0;
          wp <= '0;
          kcnt <= '0;
        end
        CMD_WALK_STEP: begin
          steps <= steps + 1'b1;
          wp <= wp + 1'b1;
          if (kcnt != PATH_MAX) begin
            kcnt <= kcnt + 1'b1;
          end
        end
        CMD_DIST_OUT: begin
          rp <= wp - 1'b1;
          rem <= kcnt;
        end
        CMD_PATH_RD: begin
          rp <= rp - 1'b1;
          rem <= rem - 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    load_out = 1'b1;
    res_next = '0;
    case (cmd.op)
      CMD_DROP:      res_next = '{KIND_DROPPED, '0, 1'b0, 1'b1};
      CMD_ADD_LINK:  res_next = '{KIND_STORED, '0, 1'b0, 1'b1};
      CMD_Q_UNREACH: res_next = '{KIND_DIST, '0, 1'b1, 1'b1};
      CMD_Q_ZERO:    res_next = '{KIND_DIST, '0, 1'b0, 1'b1};
      CMD_DIST_OUT:  res_next = '{KIND_DIST, dist_rd, 1'b0, kcnt == '0};
      CMD_PATH_OUT:  res_next = '{KIND_PATH, 22'(st_rd), 1'b0, rem == '0};
      default:       load_out = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (res_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res_data <= res_next;
    end
  end

  assign res_valid = out_valid;

  assign status.is_query       = it.req_type != REQ_ADD;
  assign status.bad_node       = (32'(it.src_node) >= NODES) || (32'(it.dst_node) >= NODES);
  assign status.full           = edge_count == EB'(EDGES);
  assign status.same_node      = it.src_node == it.dst_node;
  assign status.out_free       = !out_valid || res_ready;
  assign status.frontier_empty = now_n == '0;
  assign status.round_done     = i == now_n;
  assign status.edge_end       = e >= edge_count;
  assign status.walk_go        = (pred_rd != s_idx) && (32'(steps) < NODES);
  assign status.dest_reached   = dist_vrd;
  assign status.want_path      = it.want_path;
  assign status.path_empty     = kcnt == '0;
  assign status.path_last      = rem == '0;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(edge_count) <= EDGES) else $error("edge count beyond table size");

  a_next_bound: assert property (@(posedge clk) disable iff (rst)
    32'(next_n) <= NODES) else $error("next frontier overfilled");

  a_frontier_reached: assert property (@(posedge clk) disable iff (rst)
    cmd.op == CMD_NODE_E |-> dist_vrd) else $error("frontier node without distance");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (load_out && out_valid) |-> res_ready) else $error("pending result overwritten");

endmodule

### rtl/frontier_shortest_path_query.sv
// Top level of the frontier shortest-path query engine.
// Add edge: the request is latched, the edge written, then the link updated and
// the result registered once the output is free. Query: each round reads every
// frontier node and relaxes its edges, then predecessors are walked and emitted.
// One transaction is worked on at a time; the edge and distance memories set the pace.
// Synchronous reset empties the edge table at once; no clearing pass is run.
`timescale 1ns / 1ps
module frontier_shortest_path_query import fspq_pkg::*; #(
  parameter int unsigned NODES       = 64,
  parameter int unsigned EDGES       = 1024,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input logic        clk,
  input logic        rst,
  fspq_req_if.sink   req,
  fspq_res_if.source res
);

  cmd_t    cmd;
  status_t status;
  logic    ready;

  fspq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (ready),
    .status    (status),
    .cmd       (cmd)
  );

  fspq_dp #(
    .NODES       (NODES),
    .EDGES       (EDGES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req_data  (req.data),
    .status    (status),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_data  (res.data)
  );

  assign req.ready = ready;

endmodule
